FILE: design/srp_pkg.sv
`default_nettype none

package srp_pkg;

    // default number of slots
    localparam int SLOTS_DEF = 16;

    // field widths
    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 4;
    localparam int STATE_W  = 2;
    localparam int TIME_W   = 32;

    // request action codes
    localparam logic [ACTION_W-1:0] ACT_SET_STATE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_TOUCH      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PIN        = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_PINS = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLAIM      = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_FIND_LOAD  = 3'd5;

    // slot state codes
    localparam logic [STATE_W-1:0] ST_FREE    = 2'd0;
    localparam logic [STATE_W-1:0] ST_LOADING = 2'd1;
    localparam logic [STATE_W-1:0] ST_READY   = 2'd2;
    localparam logic [STATE_W-1:0] ST_MISSING = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_seq_state;

endpackage

`default_nettype wire

FILE: design/slot_replacement_policy_top.sv
`default_nettype none

// channel   | signals                                              | handshake
// ----------+------------------------------------------------------+----------------------------
// request   | i_action i_slot_index i_new_state i_set_touch i_now_ms | taken when start && !busy
// result    | o_found o_slot_out                                   | o_valid, one cycle, no stall
//
// set state, touch, pin, clear pins and unknown actions: result in the cycle after the request
// claim victim and find loading: scan every slot, busy throughout; the age memory has one
//   read port, so one slot is read and compared per cycle through a single comparator
// reset is synchronous and clears slot states, pins and per-slot stamp bits
// the receiver cannot stall; each result is shown for exactly one cycle

module slot_replacement_policy_top #(
    parameter int SLOTS = srp_pkg::SLOTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [srp_pkg::ACTION_W-1:0]  i_action,
    input  wire [srp_pkg::INDEX_W-1:0]   i_slot_index,
    input  wire [srp_pkg::STATE_W-1:0]   i_new_state,
    input  wire                          i_set_touch,
    input  wire [srp_pkg::TIME_W-1:0]    i_now_ms,
    output logic                         o_valid,
    output logic                         o_found,
    output logic [srp_pkg::INDEX_W-1:0]  o_slot_out
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = IW + 1;
    localparam int AW = (IW > srp_pkg::INDEX_W) ? IW : srp_pkg::INDEX_W;

    // sequencer
    srp_pkg::t_seq_state r_state, n_state;

    // slot status flops
    logic [srp_pkg::STATE_W-1:0] r_slot_st [SLOTS];
    logic [SLOTS-1:0]            r_pin;
    logic [SLOTS-1:0]            r_stamped;

    // age memory
    logic [srp_pkg::TIME_W-1:0]  r_age_mem [SLOTS];
    logic [srp_pkg::TIME_W-1:0]  r_rd_data;

    // scan pipeline
    logic [CW-1:0]               r_rd_cnt;
    logic                        r_cmp_v;
    logic [IW-1:0]               r_cmp_idx;

    // scan results
    logic                        r_has_free, r_has_load, r_has_m, r_has_r;
    logic [IW-1:0]               r_free_idx, r_load_idx, r_m_idx, r_r_idx;
    logic [srp_pkg::TIME_W-1:0]  r_best_m, r_best_r;

    // latched request
    logic [srp_pkg::ACTION_W-1:0] r_action;
    logic [srp_pkg::INDEX_W-1:0]  r_echo;

    // result registers
    logic                        r_valid, r_found;
    logic [srp_pkg::INDEX_W-1:0] r_slot_out;

    // request decode
    logic                        accept;
    logic [AW-1:0]               idx_ext;
    logic [IW-1:0]               addr;
    logic                        in_range;
    logic [srp_pkg::STATE_W-1:0] addr_st;
    logic                        pin_ok;

    // memory write port
    logic                        w_we;

    // compare stage
    logic [srp_pkg::STATE_W-1:0] cmp_st;
    logic                        cmp_pin;
    logic [srp_pkg::TIME_W-1:0]  cmp_age;
    logic                        cls_missing;
    logic                        cls_has;
    logic [srp_pkg::TIME_W-1:0]  cls_best;
    logic                        age_lt;
    logic                        cand;

    // finish decision
    logic                        fin_found;
    logic [IW-1:0]               fin_idx;
    logic                        fin_claim;

    assign accept   = start && (r_state == srp_pkg::S_IDLE);
    assign idx_ext  = AW'(i_slot_index);
    assign addr     = idx_ext[IW-1:0];
    assign in_range = (32'(i_slot_index) < 32'(SLOTS));
    assign addr_st  = r_slot_st[addr];
    assign pin_ok   = in_range &&
                      ((addr_st == srp_pkg::ST_LOADING) || (addr_st == srp_pkg::ST_READY));

    // age write on stamping requests
    always_comb begin
        w_we = 1'b0;
        if (accept) begin
            unique case (i_action)
                srp_pkg::ACT_SET_STATE: w_we = in_range && i_set_touch;
                srp_pkg::ACT_TOUCH:     w_we = in_range;
                srp_pkg::ACT_PIN:       w_we = pin_ok;
                default:                w_we = 1'b0;
            endcase
        end
    end

    // age memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_age_mem[addr] <= i_now_ms;
        end
        r_rd_data <= r_age_mem[r_rd_cnt[IW-1:0]];
    end

    // compare stage: one shared comparator against the class best
    assign cmp_st      = r_slot_st[r_cmp_idx];
    assign cmp_pin     = r_pin[r_cmp_idx];
    assign cmp_age     = r_stamped[r_cmp_idx] ? r_rd_data : '0;
    assign cls_missing = (cmp_st == srp_pkg::ST_MISSING);
    assign cls_has     = cls_missing ? r_has_m : r_has_r;
    assign cls_best    = cls_missing ? r_best_m : r_best_r;
    assign age_lt      = (cmp_age < cls_best);
    assign cand        = !cmp_pin &&
                         ((cmp_st == srp_pkg::ST_MISSING) || (cmp_st == srp_pkg::ST_READY)) &&
                         (!cls_has || age_lt);

    // finish decision
    always_comb begin
        fin_found = 1'b0;
        fin_idx   = r_free_idx;
        fin_claim = 1'b0;
        if (r_action == srp_pkg::ACT_CLAIM) begin
            priority if (r_has_free) begin
                fin_found = 1'b1;
                fin_idx   = r_free_idx;
            end else if (r_has_m) begin
                fin_found = 1'b1;
                fin_idx   = r_m_idx;
            end else if (r_has_r) begin
                fin_found = 1'b1;
                fin_idx   = r_r_idx;
            end
            fin_claim = fin_found;
        end else begin
            fin_found = r_has_load;
            fin_idx   = r_load_idx;
        end
    end

    // next sequencer state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srp_pkg::S_IDLE: begin
                if (accept && ((i_action == srp_pkg::ACT_CLAIM) ||
                               (i_action == srp_pkg::ACT_FIND_LOAD))) begin
                    n_state = srp_pkg::S_SCAN;
                end
            end
            srp_pkg::S_SCAN: begin
                if (r_cmp_v && (r_cmp_idx == IW'(SLOTS - 1))) begin
                    n_state = srp_pkg::S_FINISH;
                end
            end
            srp_pkg::S_FINISH: n_state = srp_pkg::S_IDLE;
            default:           n_state = srp_pkg::S_IDLE;
        endcase
    end

    // control registers and slot status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= srp_pkg::S_IDLE;
            r_pin      <= '0;
            r_stamped  <= '0;
            r_valid    <= 1'b0;
            r_cmp_v    <= 1'b0;
            r_rd_cnt   <= '0;
            r_has_free <= 1'b0;
            r_has_load <= 1'b0;
            r_has_m    <= 1'b0;
            r_has_r    <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_st[i] <= srp_pkg::ST_FREE;
            end
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (w_we) begin
                r_stamped[addr] <= 1'b1;
            end
            unique case (r_state)
                srp_pkg::S_IDLE: begin
                    if (accept) begin
                        r_action   <= i_action;
                        r_echo     <= i_slot_index;
                        r_slot_out <= i_slot_index;
                        r_found    <= 1'b0;
                        r_rd_cnt   <= '0;
                        r_cmp_v    <= 1'b0;
                        r_has_free <= 1'b0;
                        r_has_load <= 1'b0;
                        r_has_m    <= 1'b0;
                        r_has_r    <= 1'b0;
                        unique case (i_action)
                            srp_pkg::ACT_SET_STATE: begin
                                r_valid <= 1'b1;
                                if (in_range) begin
                                    r_slot_st[addr] <= i_new_state;
                                    if ((i_new_state == srp_pkg::ST_FREE) ||
                                        (i_new_state == srp_pkg::ST_LOADING)) begin
                                        r_pin[addr] <= 1'b0;
                                    end
                                end
                            end
                            srp_pkg::ACT_PIN: begin
                                r_valid <= 1'b1;
                                if (pin_ok) begin
                                    r_pin[addr] <= 1'b1;
                                    r_found     <= 1'b1;
                                end
                            end
                            srp_pkg::ACT_CLEAR_PINS: begin
                                r_valid <= 1'b1;
                                r_pin   <= '0;
                            end
                            srp_pkg::ACT_CLAIM, srp_pkg::ACT_FIND_LOAD: begin
                                r_valid <= 1'b0;
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                srp_pkg::S_SCAN: begin
                    // issue one read per cycle
                    if (r_rd_cnt < CW'(SLOTS)) begin
                        r_cmp_v   <= 1'b1;
                        r_cmp_idx <= r_rd_cnt[IW-1:0];
                        r_rd_cnt  <= r_rd_cnt + CW'(1);
                    end else begin
                        r_cmp_v <= 1'b0;
                    end
                    // compare the slot read last cycle
                    if (r_cmp_v) begin
                        if ((cmp_st == srp_pkg::ST_FREE) && !r_has_free) begin
                            r_has_free <= 1'b1;
                            r_free_idx <= r_cmp_idx;
                        end
                        if ((cmp_st == srp_pkg::ST_LOADING) && !r_has_load) begin
                            r_has_load <= 1'b1;
                            r_load_idx <= r_cmp_idx;
                        end
                        if (cand && cls_missing) begin
                            r_has_m  <= 1'b1;
                            r_m_idx  <= r_cmp_idx;
                            r_best_m <= cmp_age;
                        end
                        if (cand && !cls_missing) begin
                            r_has_r  <= 1'b1;
                            r_r_idx  <= r_cmp_idx;
                            r_best_r <= cmp_age;
                        end
                    end
                end
                srp_pkg::S_FINISH: begin
                    r_valid <= 1'b1;
                    r_found <= fin_found;
                    r_slot_out <= fin_found ? srp_pkg::INDEX_W'(AW'(fin_idx)) : r_echo;
                    if (fin_claim) begin
                        r_slot_st[fin_idx] <= srp_pkg::ST_FREE;
                        r_pin[fin_idx]     <= 1'b0;
                    end
                end
                default: begin
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign busy       = (r_state != srp_pkg::S_IDLE);
    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_slot_out = r_slot_out;

endmodule

`default_nettype wire

FILE: design/srp_checker.sv
`default_nettype none

module srp_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          start,
    input wire                          busy,
    input wire [srp_pkg::ACTION_W-1:0]  i_action,
    input wire                          o_valid
);

    logic scan_req;

    assign scan_req = (i_action == srp_pkg::ACT_CLAIM) || (i_action == srp_pkg::ACT_FIND_LOAD);

    // a result is never shown while a search is running
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // non-search requests answer on the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !scan_req) |=> (o_valid && !busy))
        else $error("missing result for single-cycle request");

    // search requests go busy at once
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && scan_req) |=> (busy && !o_valid))
        else $error("search request did not go busy");

    // busy rises only on an accepted request
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // the end of a search delivers its result
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("search ended without a result");

endmodule

bind slot_replacement_policy_top srp_checker u_srp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_action (i_action),
    .o_valid  (o_valid)
);

`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none

module tb_top;

    localparam int NSLOTS        = srp_pkg::SLOTS_DEF;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int CYCLE_LIMIT   = 400000;

    // action codes the block leaves undecoded
    localparam logic [srp_pkg::ACTION_W-1:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [srp_pkg::ACTION_W-1:0] ACT_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [srp_pkg::ACTION_W-1:0] action;
        logic [srp_pkg::INDEX_W-1:0]  slot_index;
        logic [srp_pkg::STATE_W-1:0]  new_state;
        logic                         set_touch;
        logic [srp_pkg::TIME_W-1:0]   now_ms;
    } t_req;

    typedef struct packed {
        logic                        found;
        logic [srp_pkg::INDEX_W-1:0] slot_out;
    } t_slot_result;

    // clock, reset and block inputs
    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         start        = 1'b0;
    logic [srp_pkg::ACTION_W-1:0] i_action     = '0;
    logic [srp_pkg::INDEX_W-1:0]  i_slot_index = '0;
    logic [srp_pkg::STATE_W-1:0]  i_new_state  = '0;
    logic                         i_set_touch  = 1'b0;
    logic [srp_pkg::TIME_W-1:0]   i_now_ms     = '0;

    logic                        busy;
    logic                        o_valid;
    logic                        o_found;
    logic [srp_pkg::INDEX_W-1:0] o_slot_out;

    // predicted slot table
    logic [srp_pkg::STATE_W-1:0] slot_st  [NSLOTS];
    logic                        slot_pin [NSLOTS];
    logic [srp_pkg::TIME_W-1:0]  slot_age [NSLOTS];

    t_req         queued_reqs[$];
    t_slot_result pending_results[$];
    t_req         cur_req;
    int           gap_left     = 0;
    int           burst_left   = 0;
    int           n_counted    = 0;
    int           n_mismatch   = 0;
    int unsigned  cycle_count  = 0;
    logic [srp_pkg::TIME_W-1:0] wall_ms = '0;
    logic [srp_pkg::TIME_W-1:0] tie_ms  = '0;

    slot_replacement_policy_top #(
        .SLOTS(NSLOTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_slot_index(i_slot_index),
        .i_new_state (i_new_state),
        .i_set_touch (i_set_touch),
        .i_now_ms    (i_now_ms),
        .o_valid     (o_valid),
        .o_found     (o_found),
        .o_slot_out  (o_slot_out)
    );

    // 10 unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // lowest slot holding a state, or -1
    function automatic int lowest_with(logic [srp_pkg::STATE_W-1:0] st);
        for (int i = 0; i < NSLOTS; i++) begin
            if (slot_st[i] == st) return i;
        end
        return -1;
    endfunction

    // least recently touched unpinned slot in a state, lower index on ties
    function automatic int oldest_unpinned(logic [srp_pkg::STATE_W-1:0] st);
        int pick;
        logic [srp_pkg::TIME_W-1:0] best;
        pick = -1;
        best = '1;
        for (int i = 0; i < NSLOTS; i++) begin
            if (slot_st[i] == st && !slot_pin[i] && (pick < 0 || slot_age[i] < best)) begin
                best = slot_age[i];
                pick = i;
            end
        end
        return pick;
    endfunction

    // free first, then missing, then ready; loading never
    function automatic int victim_slot();
        int v;
        v = lowest_with(srp_pkg::ST_FREE);
        if (v < 0) v = oldest_unpinned(srp_pkg::ST_MISSING);
        if (v < 0) v = oldest_unpinned(srp_pkg::ST_READY);
        return v;
    endfunction

    // update the slot table for one request and return its result
    function automatic t_slot_result apply_request(t_req r);
        t_slot_result res;
        int v;
        bit in_range;
        in_range = int'(r.slot_index) < NSLOTS;
        res.found = 1'b0;
        res.slot_out = r.slot_index;
        case (r.action)
            srp_pkg::ACT_SET_STATE: begin
                if (in_range) begin
                    slot_st[r.slot_index] = r.new_state;
                    if (r.new_state == srp_pkg::ST_FREE || r.new_state == srp_pkg::ST_LOADING)
                        slot_pin[r.slot_index] = 1'b0;
                    if (r.set_touch) slot_age[r.slot_index] = r.now_ms;
                end
            end
            srp_pkg::ACT_TOUCH: begin
                if (in_range) slot_age[r.slot_index] = r.now_ms;
            end
            srp_pkg::ACT_PIN: begin
                if (in_range && (slot_st[r.slot_index] == srp_pkg::ST_LOADING ||
                                 slot_st[r.slot_index] == srp_pkg::ST_READY)) begin
                    slot_pin[r.slot_index] = 1'b1;
                    slot_age[r.slot_index] = r.now_ms;
                    res.found = 1'b1;
                end
            end
            srp_pkg::ACT_CLEAR_PINS: begin
                for (int i = 0; i < NSLOTS; i++) slot_pin[i] = 1'b0;
            end
            srp_pkg::ACT_CLAIM: begin
                v = victim_slot();
                if (v >= 0) begin
                    slot_st[v] = srp_pkg::ST_FREE;
                    slot_pin[v] = 1'b0;
                    res.found = 1'b1;
                    res.slot_out = srp_pkg::INDEX_W'(v);
                end
            end
            srp_pkg::ACT_FIND_LOAD: begin
                v = lowest_with(srp_pkg::ST_LOADING);
                if (v >= 0) begin
                    res.found = 1'b1;
                    res.slot_out = srp_pkg::INDEX_W'(v);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // mostly short gaps, a few long ones, now and then a burst with none
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // time stamps: a running clock with wrap, extremes, repeats for ties
    function automatic logic [srp_pkg::TIME_W-1:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 14) return '1;
        if (r < 24) return $urandom;
        if (r < 36) return tie_ms;
        if (r < 40) tie_ms = $urandom;
        wall_ms = wall_ms + $urandom_range(0, 500);
        return wall_ms;
    endfunction

    function automatic logic [srp_pkg::STATE_W-1:0] pick_held_state();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return srp_pkg::ST_LOADING;
        if (r < 60) return srp_pkg::ST_READY;
        return srp_pkg::ST_MISSING;
    endfunction

    // random field values at field width
    function automatic logic [srp_pkg::STATE_W-1:0] rand_state();
        return srp_pkg::STATE_W'($urandom_range(0, 3));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic queue_req(logic [srp_pkg::ACTION_W-1:0] act, int idx,
                             logic [srp_pkg::STATE_W-1:0] st,
                             logic stamp, logic [srp_pkg::TIME_W-1:0] ms);
        t_req r;
        r.action = act;
        r.slot_index = srp_pkg::INDEX_W'(idx);
        r.new_state = st;
        r.set_touch = stamp;
        r.now_ms = ms;
        queued_reqs.push_back(r);
        if (act <= srp_pkg::ACT_FIND_LOAD) n_counted++;
    endtask

    // driver: predict on acceptance, then load the next request after its gap
    always @(posedge i_clk) begin : driver
        t_req nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) pending_results.push_back(apply_request(cur_req));
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    start <= 1'b0;
                    gap_left--;
                end else if (queued_reqs.size() != 0) begin
                    nxt = queued_reqs.pop_front();
                    cur_req = nxt;
                    i_action <= nxt.action;
                    i_slot_index <= nxt.slot_index;
                    i_new_state <= nxt.new_state;
                    i_set_touch <= nxt.set_touch;
                    i_now_ms <= nxt.now_ms;
                    start <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: outputs are stable mid-cycle, compare against the oldest prediction
    always @(negedge i_clk) begin : monitor
        t_slot_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual found %0d slot %0d",
                         $time, o_found, o_slot_out);
                n_mismatch++;
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found) begin
                    $display("%0t: found mismatch, expected %0d actual %0d",
                             $time, want.found, o_found);
                    n_mismatch++;
                end
                if (o_slot_out !== want.slot_out) begin
                    $display("%0t: slot_out mismatch, expected %0d actual %0d",
                             $time, want.slot_out, o_slot_out);
                    n_mismatch++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        int r;
        int v;
        logic [srp_pkg::STATE_W-1:0] st;
        logic [srp_pkg::TIME_W-1:0] ms;

        for (int i = 0; i < NSLOTS; i++) begin
            slot_st[i] = srp_pkg::ST_FREE;
            slot_pin[i] = 1'b0;
            slot_age[i] = '0;
        end
        wall_ms = $urandom;
        tie_ms = $urandom;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table: no loading slot, claim takes slot 0, pin of a free slot fails
        queue_req(srp_pkg::ACT_FIND_LOAD, 9, srp_pkg::ST_MISSING, 1'b1, 32'h0);
        queue_req(srp_pkg::ACT_CLAIM, 6, srp_pkg::ST_READY, 1'b0, 32'h1234_5678);
        queue_req(srp_pkg::ACT_PIN, 3, srp_pkg::ST_LOADING, 1'b1, 32'hFFFF_FFFF);
        queue_req(ACT_UNUSED_6, 15, srp_pkg::ST_MISSING, 1'b1, 32'hFFFF_FFFF);
        queue_req(ACT_UNUSED_7, 0, srp_pkg::ST_FREE, 1'b0, 32'h0);

        // fill every slot; slot 14 keeps its reset stamp, ties among ready and missing
        for (int i = 0; i < NSLOTS; i++) begin
            if (i < 2) begin
                st = srp_pkg::ST_LOADING;
                ms = $urandom;
            end else if (i < 12) begin
                st = srp_pkg::ST_READY;
                ms = (i == 3 || i == 5) ? 32'h0 : (32'h8000_0000 | i);
            end else begin
                st = srp_pkg::ST_MISSING;
                ms = (i == 15) ? 32'hFFFF_FFFF : 32'h10;
            end
            queue_req(srp_pkg::ACT_SET_STATE, i, st, i != 14, ms);
        end

        // oldest missing, then tie on equal stamps, then an all-ones stamp wins
        queue_req(srp_pkg::ACT_CLAIM, 0, srp_pkg::ST_FREE, 1'b0, 32'h0);
        queue_req(srp_pkg::ACT_SET_STATE, 14, srp_pkg::ST_LOADING, 1'b0, 32'h0);
        queue_req(srp_pkg::ACT_PIN, 1, srp_pkg::ST_FREE, 1'b0, 32'h5);
        queue_req(srp_pkg::ACT_CLAIM, 7, srp_pkg::ST_FREE, 1'b0, 32'h0);
        queue_req(srp_pkg::ACT_SET_STATE, 12, srp_pkg::ST_MISSING, 1'b1, 32'hFFFF_FFFF);
        queue_req(srp_pkg::ACT_TOUCH, 13, srp_pkg::ST_FREE, 1'b0, 32'hFFFF_FFFF);
        queue_req(srp_pkg::ACT_CLAIM, 2, srp_pkg::ST_FREE, 1'b0, 32'h0);
        queue_req(srp_pkg::ACT_FIND_LOAD, 11, srp_pkg::ST_FREE, 1'b0, 32'h0);
        queue_req(srp_pkg::ACT_CLEAR_PINS, 4, srp_pkg::ST_READY, 1'b1, 32'hAAAA_5555);

        n_counted = 0;
        while (n_counted < RANDOM_ITEMS) begin
            // build each sequence from the settled table
            do @(negedge i_clk); while (queued_reqs.size() != 0 || start);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                // claim a victim, load it, then mark it ready or missing
                v = victim_slot();
                queue_req(srp_pkg::ACT_CLAIM, $urandom_range(0, 15), rand_state(),
                          rand_bit(), $urandom);
                if (v >= 0) begin
                    queue_req(srp_pkg::ACT_SET_STATE, v, srp_pkg::ST_LOADING, rand_bit(),
                              pick_time());
                    if ($urandom_range(0, 2) == 0)
                        queue_req(srp_pkg::ACT_FIND_LOAD, $urandom_range(0, 15),
                                  srp_pkg::ST_FREE, 1'b0, $urandom);
                    if ($urandom_range(0, 3) == 0)
                        queue_req(srp_pkg::ACT_PIN, v, srp_pkg::ST_FREE, 1'b0, pick_time());
                    queue_req(srp_pkg::ACT_SET_STATE, v,
                              ($urandom_range(0, 3) == 0) ? srp_pkg::ST_MISSING :
                                                            srp_pkg::ST_READY,
                              $urandom_range(0, 9) != 0, pick_time());
                end else begin
                    queue_req(srp_pkg::ACT_CLEAR_PINS, $urandom_range(0, 15),
                              srp_pkg::ST_FREE, 1'b0, $urandom);
                end
                repeat ($urandom_range(0, 3))
                    queue_req(srp_pkg::ACT_TOUCH, $urandom_range(0, 15), rand_state(),
                              rand_bit(), pick_time());
            end else if (r < 65) begin
                // occupy every free slot
                for (int i = 0; i < NSLOTS; i++) begin
                    if (slot_st[i] == srp_pkg::ST_FREE)
                        queue_req(srp_pkg::ACT_SET_STATE, i, pick_held_state(),
                                  $urandom_range(0, 9) != 0, pick_time());
                end
                queue_req(srp_pkg::ACT_CLAIM, $urandom_range(0, 15), srp_pkg::ST_FREE, 1'b0,
                          $urandom);
            end else if (r < 80) begin
                // pins on random slots, sometimes cleared again
                repeat ($urandom_range(1, 6))
                    queue_req(srp_pkg::ACT_PIN, $urandom_range(0, 15), rand_state(),
                              rand_bit(), pick_time());
                if ($urandom_range(0, 2) == 0)
                    queue_req(srp_pkg::ACT_CLEAR_PINS, $urandom_range(0, 15),
                              srp_pkg::ST_FREE, 1'b0, $urandom);
                queue_req(srp_pkg::ACT_FIND_LOAD, $urandom_range(0, 15), srp_pkg::ST_FREE,
                          1'b0, $urandom);
            end else if (r < 85) begin
                // leave no candidate: ready slots pinned, all others loading
                for (int i = 0; i < NSLOTS; i++) begin
                    if (slot_st[i] == srp_pkg::ST_READY)
                        queue_req(srp_pkg::ACT_PIN, i, srp_pkg::ST_FREE, 1'b0, pick_time());
                    else
                        queue_req(srp_pkg::ACT_SET_STATE, i, srp_pkg::ST_LOADING, rand_bit(),
                                  pick_time());
                end
                queue_req(srp_pkg::ACT_CLAIM, $urandom_range(0, 15), rand_state(),
                          1'b1, $urandom);
                queue_req(srp_pkg::ACT_FIND_LOAD, $urandom_range(0, 15), srp_pkg::ST_FREE,
                          1'b0, $urandom);
                queue_req(srp_pkg::ACT_CLEAR_PINS, $urandom_range(0, 15), srp_pkg::ST_FREE,
                          1'b0, $urandom);
            end else begin
                // unstructured requests over every field value
                repeat ($urandom_range(2, 8))
                    queue_req(srp_pkg::ACTION_W'($urandom_range(0, 7)), $urandom_range(0, 15),
                              rand_state(), rand_bit(), $urandom);
            end
        end

        // drain, then allow one full scan for any stray result
        do @(negedge i_clk);
        while (queued_reqs.size() != 0 || start || pending_results.size() != 0);
        repeat (NSLOTS + 4) @(posedge i_clk);

        if (n_mismatch == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
